// ----- hdl/thp_pkg.sv -----
`timescale 1ns / 1ps
package thp_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TEMP = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LO = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_HI = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MIXED = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM = 3'd4;

  // Commands carried by an input beat
  localparam logic [1:0] CMD_TEMP = 2'd0;
  localparam logic [1:0] CMD_HUM = 2'd1;
  localparam logic [1:0] CMD_PRESS = 2'd2;
  localparam logic [1:0] CMD_ALL = 2'd3;

  localparam logic [31:0] HUM_MAX = 32'd419430400;
  localparam logic [16:0] HUM_OUT_MAX = 17'd102400;

  // Datapath micro-operations; most use the one shared multiplier
  typedef enum logic [4:0] {
    UOP_T0, UOP_T1, UOP_T2, UOP_T3,
    UOP_HV, UOP_H0, UOP_H1, UOP_H2, UOP_H3, UOP_H4, UOP_H5, UOP_H6, UOP_H7, UOP_H8,
    UOP_P0, UOP_P1, UOP_P2, UOP_P3, UOP_P5, UOP_P6, UOP_P7, UOP_P8, UOP_PDIV,
    UOP_P9, UOP_P10, UOP_P11, UOP_P12, UOP_P13
  } uop_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    uop_e uop;
  } thp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_zero;
  } thp_status_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic uop_e first_uop(input logic [1:0] cmd);
    uop_e u;
    unique case (cmd)
      CMD_HUM: u = UOP_HV;
      CMD_PRESS: u = UOP_P0;
      default: u = UOP_T0;
    endcase
    return u;
  endfunction

  function automatic logic is_last(input uop_e u, input logic [1:0] cmd);
    logic l;
    l = 1'b0;
    if (u == UOP_P13) l = 1'b1;
    if ((u == UOP_T3 || u == UOP_H8) && cmd != CMD_ALL) l = 1'b1;
    return l;
  endfunction

  function automatic uop_e next_uop(input uop_e u);
    uop_e n;
    unique case (u)
      UOP_T3: n = UOP_HV;
      UOP_H8: n = UOP_P0;
      UOP_P13: n = UOP_P13;
      default: n = uop_e'(u + 5'd1);
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/thp_in_if.sv -----
`timescale 1ns / 1ps
interface thp_in_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, cmd, raw_temperature, raw_pressure, raw_humidity,
                  input ready);
  modport sink (input valid, cmd, raw_temperature, raw_pressure, raw_humidity,
                output ready);
endinterface

// ----- hdl/thp_out_if.sv -----
`timescale 1ns / 1ps
interface thp_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] temperature;
  logic [16:0] humidity;
  logic [31:0] pressure;

  modport source (output valid, temperature, humidity, pressure, input ready);
  modport sink (input valid, temperature, humidity, pressure, output ready);
endinterface

// ----- hdl/thp_div.sv -----
`timescale 1ns / 1ps
module thp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  logic [32:0] rem_q, rem_d, rem_sh;
  logic [31:0] quo_q, quo_d, dvs_q;
  logic [4:0] cnt_q;
  logic busy_q, done_q;

  // restoring, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[31:0], quo_q[31]};
    if (rem_sh >= {1'b0, dvs_q}) begin
      rem_d = rem_sh - {1'b0, dvs_q};
      quo_d = {quo_q[30:0], 1'b1};
    end else begin
      rem_d = rem_sh;
      quo_d = {quo_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;
endmodule

// ----- hdl/thp_datapath.sv -----
`timescale 1ns / 1ps
module thp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [thp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [thp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  thp_pkg::thp_cmd_t             cmd_i,
  output thp_pkg::thp_status_t          status_o,
  input  logic [19:0]                   raw_temperature_i,
  input  logic [19:0]                   raw_pressure_i,
  input  logic [15:0]                   raw_humidity_i,
  output logic signed [31:0]            temperature_o,
  output logic [16:0]                   humidity_o,
  output logic [31:0]                   pressure_o
);
  import thp_pkg::*;

  logic [47:0] tc_q, mc_q;
  logic [63:0] pl_q, ph_q;
  logic [39:0] hc_q;
  logic [31:0] fine_q;
  logic [19:0] rt_q, rp_q;
  logic [15:0] rh_q;
  logic [31:0] a_q, b_q, c_q, d_q, t_res_q, p_res_q;
  logic [16:0] h_res_q;
  logic [31:0] ma, mb, m, t1, dd, div_quo;
  logic div_done;

  assign t1 = {16'b0, tc_q[15:0]};
  assign dd = {16'b0, rt_q[19:4]} - t1;

  // operand selection for the one shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.uop)
      UOP_T0: begin
        ma = {15'b0, rt_q[19:3]} - {15'b0, tc_q[15:0], 1'b0};
        mb = sx16(tc_q[31:16]);
      end
      UOP_T1: begin ma = dd; mb = dd; end
      UOP_T2: begin ma = b_q; mb = sx16(tc_q[47:32]); end
      UOP_T3: begin ma = fine_q; mb = 32'd5; end
      UOP_H0: begin ma = sx16(hc_q[31:16]); mb = c_q; end
      UOP_H1: begin ma = c_q; mb = sx8(hc_q[39:32]); end
      UOP_H2: begin ma = c_q; mb = {24'b0, mc_q[47:40]}; end
      UOP_H3: begin ma = b_q; mb = d_q; end
      UOP_H4: begin ma = asr(b_q, 10) + 32'd2097152; mb = sx16(mc_q[39:24]); end
      UOP_H5: begin ma = a_q; mb = b_q; end
      UOP_H6: begin ma = asr(b_q, 15); mb = asr(b_q, 15); end
      UOP_H7: begin ma = d_q; mb = {24'b0, mc_q[23:16]}; end
      UOP_P1: begin ma = asr(a_q, 2); mb = asr(a_q, 2); end
      UOP_P2: begin ma = asr(c_q, 11); mb = sx16(ph_q[31:16]); end
      UOP_P3: begin ma = a_q; mb = sx16(ph_q[15:0]); end
      UOP_P5: begin ma = sx16(pl_q[47:32]); mb = asr(c_q, 13); end
      UOP_P6: begin ma = sx16(pl_q[31:16]); mb = a_q; end
      UOP_P7: begin ma = 32'd32768 + b_q; mb = {16'b0, pl_q[15:0]}; end
      UOP_P8: begin
        ma = (32'd1048576 - {12'b0, rp_q}) - asr(d_q, 12);
        mb = 32'd3125;
      end
      UOP_P10: begin ma = c_q >> 3; mb = c_q >> 3; end
      UOP_P11: begin ma = sx16(mc_q[15:0]); mb = b_q; end
      UOP_P12: begin ma = c_q >> 2; mb = sx16(ph_q[63:48]); end
      default: ;
    endcase
  end

  assign m = 32'(ma * mb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pl_q <= '0;
      ph_q <= '0;
      mc_q <= '0;
      hc_q <= '0;
      fine_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TEMP: tc_q <= cfg_data_i[47:0];
          CFG_PRESS_LO: pl_q <= cfg_data_i;
          CFG_PRESS_HI: ph_q <= cfg_data_i;
          CFG_MIXED: mc_q <= cfg_data_i[47:0];
          CFG_HUM: hc_q <= cfg_data_i[39:0];
          default: ;
        endcase
      end
      if (cmd_i.exec && cmd_i.uop == UOP_T2) fine_q <= a_q + asr(m, 14);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rt_q <= raw_temperature_i;
      rp_q <= raw_pressure_i;
      rh_q <= raw_humidity_i;
      t_res_q <= '0;
      h_res_q <= '0;
      p_res_q <= '0;
    end else if (cmd_i.exec) begin
      unique case (cmd_i.uop)
        UOP_T0: a_q <= asr(m, 11);
        UOP_T1: b_q <= asr(m, 12);
        UOP_T3: t_res_q <= asr(m + 32'd128, 8);
        UOP_HV: c_q <= fine_q - 32'd76800;
        UOP_H0: a_q <= asr({2'b0, rh_q, 14'b0} - {hc_q[11:0], 20'b0} - m + 32'd16384, 15);
        UOP_H1: b_q <= asr(m, 10);
        UOP_H2: d_q <= asr(m, 11) + 32'd32768;
        UOP_H3: b_q <= m;
        UOP_H4: b_q <= asr(m + 32'd8192, 14);
        UOP_H5: b_q <= m;
        UOP_H6: d_q <= asr(m, 7);
        UOP_H7: d_q <= b_q - asr(m, 4);
        UOP_H8: begin
          if (d_q[31]) h_res_q <= '0;
          else if (d_q > HUM_MAX) h_res_q <= HUM_OUT_MAX;
          else h_res_q <= d_q[28:12];
        end
        UOP_P0: a_q <= asr(fine_q, 1) - 32'd64000;
        UOP_P1: c_q <= m;
        UOP_P2: d_q <= m;
        UOP_P3: d_q <= asr(d_q + {m[30:0], 1'b0}, 2) + {pl_q[63:48], 16'b0};
        UOP_P5: b_q <= asr(m, 3);
        UOP_P6: b_q <= asr(b_q + asr(m, 1), 18);
        UOP_P7: a_q <= asr(m, 15);
        UOP_P8: c_q <= m;
        UOP_P9: c_q <= c_q[31] ? {div_quo[30:0], 1'b0} : div_quo;
        UOP_P10: b_q <= m >> 13;
        UOP_P11: b_q <= asr(m, 12);
        UOP_P12: d_q <= asr(m, 13);
        UOP_P13: p_res_q <= c_q + asr(b_q + d_q + sx16(ph_q[47:32]), 4);
        default: ;
      endcase
    end
  end

  thp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (c_q[31] ? c_q : {c_q[30:0], 1'b0}),
    .divisor_i  (a_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign status_o.div_done = div_done;
  assign status_o.div_zero = (a_q == '0);
  assign temperature_o = $signed(t_res_q);
  assign humidity_o = h_res_q;
  assign pressure_o = p_res_q;
endmodule

// ----- hdl/thp_ctrl.sv -----
`timescale 1ns / 1ps
module thp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_cmd_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output thp_pkg::thp_cmd_t    cmd_o,
  input  thp_pkg::thp_status_t status_i
);
  import thp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  uop_e uop_q, uop_d;
  logic [1:0] op_q, op_d;

  always_comb begin
    state_d = state_q;
    uop_d = uop_q;
    op_d = op_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    cmd_o = '{load: 1'b0, exec: 1'b0, div_start: 1'b0, uop: uop_q};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d = in_cmd_i;
          uop_d = first_uop(in_cmd_i);
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (uop_q == UOP_P8 && status_i.div_zero) begin
          state_d = ST_DONE;
        end else if (uop_q == UOP_PDIV) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          cmd_o.exec = 1'b1;
          if (is_last(uop_q, op_q)) state_d = ST_DONE;
          else uop_d = next_uop(uop_q);
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          uop_d = UOP_P9;
          state_d = ST_RUN;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      uop_q <= UOP_T0;
      op_q <= CMD_TEMP;
    end else begin
      state_q <= state_d;
      uop_q <= uop_d;
      op_q <= op_d;
    end
  end
endmodule

// ----- hdl/thp_sensor_compensation.sv -----
`timescale 1ns / 1ps
// Integer compensation of raw temperature, humidity and pressure readings.
// One input beat carries a command and three raw readings; one output beat
// returns temperature (0.01 degC), humidity (Q7.10 %RH, 0..102400) and
// pressure (Pa), with fields the command does not ask for set to zero.
// A temperature refreshes the stored fine temperature, which humidity and
// pressure use; it is zero after reset. All math wraps at 32 bits.
// Items are handled one at a time through a single shared 32x32 multiplier,
// one micro-operation per cycle except while the bit-serial divider that
// pressure uses is busy. Pressure stops early with a zero result when the
// divisor is zero. The next input beat is taken once the result beat has
// been taken.
// Coefficients are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
module thp_sensor_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [thp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [thp_pkg::CfgDataW-1:0] cfg_data_i,
  thp_in_if.sink                       in_i,
  thp_out_if.source                    out_o
);
  import thp_pkg::*;

  thp_cmd_t cmd;
  thp_status_t status;

  // sequence the micro-operations and the beat handshakes
  thp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // hold coefficients, fine temperature and the result registers
  thp_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .raw_temperature_i (in_i.raw_temperature),
    .raw_pressure_i    (in_i.raw_pressure),
    .raw_humidity_i    (in_i.raw_humidity),
    .temperature_o     (out_o.temperature),
    .humidity_o        (out_o.humidity),
    .pressure_o        (out_o.pressure)
  );
endmodule
